### src/skq_pkg.sv
// Shared types, constants and helper functions for the SHA-256 keystream cipher.
package skq_pkg;

    localparam int CFG_REGS = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_WORD_0  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_WORD_1  = 3'd5;

    localparam logic [30:0] CTR_MAX = 31'h7FFF_FFFF;
    localparam int BCD_DIGITS = 10;
    localparam int ONE_BLOCK_MAX_DIGITS = 7;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic [4:0] pos;
        logic       new_block;
    } req_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [39:0] bcd_inc(input logic [39:0] bcd);
        logic [39:0] res;
        logic        carry;
        logic [3:0]  d;
        res = bcd;
        carry = 1'b1;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            d = bcd[4*i +: 4];
            if (carry) begin
                if (d == 4'd9) begin
                    d = 4'd0;
                end else begin
                    d = d + 4'd1;
                    carry = 1'b0;
                end
            end
            res[4*i +: 4] = d;
        end
        return res;
    endfunction

    function automatic logic [3:0] digit_count(input logic [39:0] bcd);
        logic [3:0] n;
        n = 4'd1;
        for (int i = 1; i < BCD_DIGITS; i++) begin
            if (bcd[4*i +: 4] != 4'd0) begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

### src/skq_front.sv
// Front end: accepts requests, tags byte position and block start, queues them.
module skq_front #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    data_byte,
    input  logic          message_start,
    output skq_pkg::req_t req,
    output logic          req_valid,
    input  logic          req_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    skq_pkg::req_t    fifo_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [4:0]       pos_reg;
    logic [4:0]       pos_cur;
    logic             push;
    logic             pop;
    skq_pkg::req_t    req_new;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign req_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = req_pop && req_valid;
    assign req       = fifo_reg[rd_ptr_reg];

    assign pos_cur           = message_start ? 5'd0 : pos_reg;
    assign req_new.data      = data_byte;
    assign req_new.start     = message_start;
    assign req_new.pos       = pos_cur;
    assign req_new.new_block = pos_cur == 5'd0;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
                pos_reg    <= pos_cur + 5'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= req_new;
        end
    end

endmodule

### src/skq_sha_core.sv
// SHA-256 compression engine, one round per cycle, one or two message blocks.
module skq_sha_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          two_blocks,
    input  logic [1023:0] msg,
    output logic          done,
    output logic [255:0]  digest
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ROUND = 3'b010,
        S_FIN   = 3'b100
    } state_t;

    state_t      state_reg;
    logic [5:0]  round_reg;
    logic        second_reg;
    logic        two_reg;
    logic        done_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;
    logic [31:0] h_sum [8];
    logic [31:0] big_s0;
    logic [31:0] big_s1;
    logic [31:0] sm_s0;
    logic [31:0] sm_s1;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb
    begin
        big_s1 = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
               ^ {v_reg[4][24:0], v_reg[4][31:25]};
        big_s0 = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
               ^ {v_reg[0][21:0], v_reg[0][31:22]};
        ch     = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1     = v_reg[7] + big_s1 + ch + skq_pkg::K_ROUND[round_reg] + w_reg[0];
        t2     = big_s0 + maj;
        sm_s0  = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
               ^ (w_reg[1] >> 3);
        sm_s1  = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
               ^ (w_reg[14] >> 10);
        w_new  = w_reg[0] + sm_s0 + w_reg[9] + sm_s1;
        for (int i = 0; i < 8; i++)
        begin
            h_sum[i] = h_reg[i] + v_reg[i];
        end
    end

    assign done = done_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            digest[255 - 32*i -: 32] = h_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            round_reg  <= '0;
            second_reg <= 1'b0;
            two_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        round_reg  <= '0;
                        second_reg <= 1'b0;
                        two_reg    <= two_blocks;
                        state_reg  <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (two_reg && !second_reg)
                    begin
                        second_reg <= 1'b1;
                        round_reg  <= '0;
                        state_reg  <= S_ROUND;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= skq_pkg::H_INIT[i];
                v_reg[i] <= skq_pkg::H_INIT[i];
            end
            for (int j = 0; j < 16; j++)
            begin
                w_reg[j] <= msg[1023 - 32*j -: 32];
            end
        end
        else if (state_reg == S_ROUND)
        begin
            for (int i = 1; i < 8; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            v_reg[4] <= v_reg[3] + t1;
            v_reg[0] <= t1 + t2;
            for (int j = 0; j < 15; j++)
            begin
                w_reg[j] <= w_reg[j+1];
            end
            w_reg[15] <= w_new;
        end
        else if (state_reg == S_FIN)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_sum[i];
                v_reg[i] <= h_sum[i];
            end
            for (int j = 0; j < 16; j++)
            begin
                w_reg[j] <= msg[511 - 32*j -: 32];
            end
        end
    end

endmodule

### src/skq_back.sv
// Back end: builds the counter message, runs the hash, applies the keystream.
module skq_back (
    input  logic          clk,
    input  logic          rst_n,
    input  skq_pkg::req_t req,
    input  logic          req_valid,
    output logic          req_pop,
    input  logic [383:0]  cfg_bits,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    result_byte,
    output logic          counter_overflow
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_PREP = 4'b0010,
        B_HASH = 4'b0100,
        B_EMIT = 4'b1000
    } state_t;

    state_t             state_reg;
    skq_pkg::req_t      cur_reg;
    logic [30:0]        counter_reg;
    logic [39:0]        bcd_reg;
    logic               ovf_reg;
    logic               repeats_reg;
    logic [31:0][7:0]   ks_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_ovf_reg;

    logic [0:127][7:0]  msg_b;
    logic [3:0]         nd;
    logic [8:0]         len_bits;
    logic               two_blocks;
    logic [3:0]         dsel;
    logic               core_start;
    logic               core_done;
    logic [255:0]       digest;
    logic               emit;

    assign req_pop    = state_reg == B_IDLE && req_valid;
    assign core_start = state_reg == B_PREP;
    assign emit       = state_reg == B_EMIT && (!out_valid_reg || out_ready);

    assign out_valid        = out_valid_reg;
    assign result_byte      = out_byte_reg;
    assign counter_overflow = out_ovf_reg;

    always_comb
    begin
        msg_b      = '0;
        dsel       = '0;
        nd         = skq_pkg::digit_count(bcd_reg);
        two_blocks = nd > 4'(skq_pkg::ONE_BLOCK_MAX_DIGITS);
        len_bits   = {6'd48 + {2'b00, nd}, 3'b000};
        for (int k = 0; k < 48; k++)
        begin
            msg_b[k] = cfg_bits[383 - 8*k -: 8];
        end
        for (int k = 0; k <= skq_pkg::BCD_DIGITS; k++)
        begin
            if (4'(k) < nd)
            begin
                dsel = nd - 4'd1 - 4'(k);
                msg_b[48 + k] = 8'h30 | {4'h0, bcd_reg[4*dsel +: 4]};
            end
            else if (4'(k) == nd)
            begin
                msg_b[48 + k] = 8'h80;
            end
        end
        if (two_blocks)
        begin
            msg_b[126] = {7'b0, len_bits[8]};
            msg_b[127] = len_bits[7:0];
        end
        else
        begin
            msg_b[62] = {7'b0, len_bits[8]};
            msg_b[63] = len_bits[7:0];
        end
    end

    skq_sha_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (core_start),
        .two_blocks (two_blocks),
        .msg        (msg_b),
        .done       (core_done),
        .digest     (digest)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            counter_reg   <= '0;
            bcd_reg       <= '0;
            ovf_reg       <= 1'b0;
            repeats_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !emit)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (req.start)
                        begin
                            counter_reg <= '0;
                            bcd_reg     <= '0;
                            ovf_reg     <= 1'b0;
                            repeats_reg <= 1'b0;
                        end
                        state_reg <= req.new_block ? B_PREP : B_EMIT;
                    end
                end
                B_PREP:
                begin
                    state_reg <= B_HASH;
                end
                B_HASH:
                begin
                    if (core_done)
                    begin
                        repeats_reg <= ovf_reg;
                        if (counter_reg != skq_pkg::CTR_MAX)
                        begin
                            counter_reg <= counter_reg + 31'd1;
                            bcd_reg     <= skq_pkg::bcd_inc(bcd_reg);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        state_reg <= B_EMIT;
                    end
                end
                B_EMIT:
                begin
                    if (emit)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_pop)
        begin
            cur_reg <= req;
        end
        if (state_reg == B_HASH && core_done)
        begin
            ks_reg <= digest;
        end
        if (emit)
        begin
            out_byte_reg <= cur_reg.data ^ ks_reg[5'd31 - cur_reg.pos];
            out_ovf_reg  <= repeats_reg;
        end
    end

endmodule

### src/sha256_counter_keystream_xor.sv
// Top level of the SHA-256 counter-mode keystream cipher.
// Each request byte is XORed with one byte of a keystream block; a block is the
// SHA-256 of key || iv || decimal counter and is made at byte 0 of every 32. A
// byte that starts a block needs load, one compression of 64 rounds (one round
// per cycle), finish and emit for counters up to 7 digits, and two compressions
// above that; every other byte only passes through the back end's sequencer. A
// queue of QUEUE_DEPTH requests lets the input side keep going while a block is
// hashed.
module sha256_counter_keystream_xor #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        message_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  result_byte,
    output logic        counter_overflow,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]   cfg_reg [skq_pkg::CFG_REGS];
    logic [383:0]  cfg_bits;
    skq_pkg::req_t req;
    logic          req_valid;
    logic          req_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < skq_pkg::CFG_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                skq_pkg::CFG_KEY_WORD_0: cfg_reg[0] <= cfg_data;
                skq_pkg::CFG_KEY_WORD_1: cfg_reg[1] <= cfg_data;
                skq_pkg::CFG_KEY_WORD_2: cfg_reg[2] <= cfg_data;
                skq_pkg::CFG_KEY_WORD_3: cfg_reg[3] <= cfg_data;
                skq_pkg::CFG_IV_WORD_0:  cfg_reg[4] <= cfg_data;
                skq_pkg::CFG_IV_WORD_1:  cfg_reg[5] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_bits = {cfg_reg[0], cfg_reg[1], cfg_reg[2], cfg_reg[3], cfg_reg[4], cfg_reg[5]};

    skq_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .message_start (message_start),
        .req           (req),
        .req_valid     (req_valid),
        .req_pop       (req_pop)
    );

    skq_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .req              (req),
        .req_valid        (req_valid),
        .req_pop          (req_pop),
        .cfg_bits         (cfg_bits),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_byte      (result_byte),
        .counter_overflow (counter_overflow)
    );

endmodule

### src/skq_checker.sv
// Port-level checker for the keystream cipher, bound to the top level.
module skq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] result_byte,
    input logic       counter_overflow
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_valid && in_ready && !(out_valid && out_ready))
        begin
            pending_next = pending_reg + 8'd1;
        end
        else if (!(in_valid && in_ready) && out_valid && out_ready)
        begin
            pending_next = pending_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_byte)
            && $stable(counter_overflow))
        else $error("result changed while stalled");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 8'd0)
        else $error("result without a pending request");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> pending_reg != 8'd0)
        else $error("input stalled with nothing pending");

endmodule

bind sha256_counter_keystream_xor skq_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_byte      (result_byte),
    .counter_overflow (counter_overflow)
);

### tb/sha256_keystream_checker.sv
// Checker: predicts the keystream cipher output from observed requests and compares results.
module sha256_keystream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        message_start,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  result_byte,
    input  logic        counter_overflow,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       repeats;
    } cipher_out_t;

    cipher_out_t expected_bytes[$];

    logic [63:0]  key_iv_regs [skq_pkg::CFG_REGS];
    logic [4:0]   pos_model;
    logic [30:0]  ctr_model;
    logic         ovf_model;
    logic         rep_model;
    logic [255:0] ks_model;

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [255:0] sha_compress(input logic [255:0] hin,
                                                  input logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] hv [8];
        logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
        logic [255:0] hout;
        for (int i = 0; i < 8; i++)
            hv[i] = hin[255 - 32*i -: 32];
        for (int i = 0; i < 16; i++)
            w[i] = blk[511 - 32*i -: 32];
        for (int i = 16; i < 64; i++)
        begin
            s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
        e = hv[4]; f = hv[5]; g = hv[6]; hh = hv[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = hh + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g))
                 + skq_pkg::K_ROUND[i] + w[i];
            t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
        hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += hh;
        for (int i = 0; i < 8; i++)
            hout[255 - 32*i -: 32] = hv[i];
        return hout;
    endfunction

    function automatic logic [255:0] keystream_for(input logic [30:0] ctr);
        logic [7:0]    msg [128];
        logic [7:0]    digits [10];
        logic [31:0]   v;
        logic [63:0]   bits;
        logic [255:0]  h;
        logic [511:0]  blk;
        int            len, nd, total;
        len = 0;
        nd = 0;
        for (int i = 0; i < 128; i++)
            msg[i] = 8'h00;
        for (int i = 0; i < skq_pkg::CFG_REGS; i++)
            for (int k = 0; k < 8; k++)
            begin
                msg[len] = key_iv_regs[i][63 - 8*k -: 8];
                len++;
            end
        v = {1'b0, ctr};
        do
        begin
            digits[nd] = 8'h30 + 8'(v % 10);
            v = v / 10;
            nd++;
        end
        while (v != 0 && nd < 10);
        while (nd > 0)
        begin
            nd--;
            msg[len] = digits[nd];
            len++;
        end
        bits = 64'(len) * 8;
        msg[len] = 8'h80;
        total = (len + 9 <= 64) ? 64 : 128;
        for (int i = 0; i < 8; i++)
            msg[total - 1 - i] = bits[8*i +: 8];
        for (int i = 0; i < 8; i++)
            h[255 - 32*i -: 32] = skq_pkg::H_INIT[i];
        for (int bi = 0; bi < total; bi += 64)
        begin
            for (int i = 0; i < 64; i++)
                blk[511 - 8*i -: 8] = msg[bi + i];
            h = sha_compress(h, blk);
        end
        return h;
    endfunction

    assign pending = expected_bytes.size();

    always @(posedge clk or negedge rst_n)
    begin
        cipher_out_t exp_item;
        if (!rst_n)
        begin
            for (int i = 0; i < skq_pkg::CFG_REGS; i++)
                key_iv_regs[i] = '0;
            pos_model = '0;
            ctr_model = '0;
            ovf_model = 1'b0;
            rep_model = 1'b0;
            ks_model = '0;
            errors = 0;
            expected_bytes.delete();
        end
        else
        begin
            if (cfg_we && cfg_index < skq_pkg::CFG_REGS)
                key_iv_regs[cfg_index] = cfg_data;
            if (in_valid && in_ready)
            begin
                if (message_start)
                begin
                    pos_model = '0;
                    ctr_model = '0;
                    ovf_model = 1'b0;
                    rep_model = 1'b0;
                end
                if (pos_model == 5'd0)
                begin
                    ks_model = keystream_for(ctr_model);
                    rep_model = ovf_model;
                    if (ctr_model < skq_pkg::CTR_MAX)
                        ctr_model = ctr_model + 31'd1;
                    else
                        ovf_model = 1'b1;
                end
                exp_item.cipher_byte = data_byte ^ ks_model[255 - 8*pos_model -: 8];
                exp_item.repeats = rep_model;
                expected_bytes.push_back(exp_item);
                pos_model = pos_model + 5'd1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result byte %h overflow %b", $time,
                             result_byte, counter_overflow);
                    errors++;
                end
                else
                begin
                    exp_item = expected_bytes.pop_front();
                    if (result_byte !== exp_item.cipher_byte)
                    begin
                        $display("%0t: result_byte expected %h actual %h", $time,
                                 exp_item.cipher_byte, result_byte);
                        errors++;
                    end
                    if (counter_overflow !== exp_item.repeats)
                    begin
                        $display("%0t: counter_overflow expected %b actual %b", $time,
                                 exp_item.repeats, counter_overflow);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

### tb/tb.sv
// Testbench top: drives requests, config writes and output stalls for the keystream cipher.
module tb;

    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        message_start;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  result_byte;
    logic        counter_overflow;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    int          errors;
    int          pending;
    int          cycle_count;
    int          burst_left;
    int          sent_count;
    int          stall_mode;
    int          stall_phase;

    sha256_counter_keystream_xor dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .message_start(message_start),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_byte(result_byte), .counter_overflow(counter_overflow),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    sha256_keystream_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .message_start(message_start),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_byte(result_byte), .counter_overflow(counter_overflow),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        message_start = 1'b0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        sent_count = 0;
        stall_mode = 0;
        stall_phase = 0;
        cycle_count = 0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[sha256_counter_keystream_xor] ERROR");
            $finish;
        end
    end

    // receiver stall pattern, with a randomly chosen mode
    always @(negedge clk)
    begin
        stall_phase++;
        if (stall_phase >= 100)
        begin
            stall_phase = 0;
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: out_ready = 1'b1;
            1: out_ready = 1'($urandom_range(0, 1));
            2: out_ready = ($urandom_range(0, 7) == 0);
            default: out_ready = (stall_phase % 5 != 0);
        endcase
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic cfg_all(input int flavor);
        logic [63:0] val;
        for (int i = 0; i < skq_pkg::CFG_REGS; i++)
        begin
            case (flavor)
                0: val = '0;
                1: val = '1;
                default: val = {$urandom, $urandom};
            endcase
            cfg_write(3'(i), val);
        end
    endtask

    task automatic wait_idle();
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_request(input logic [7:0] d, input logic s);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid = 1'b1;
        data_byte = d;
        message_start = s;
        #1;
        while (!in_ready)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        sent_count++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cfg_all(0);
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b0);
        send_request(8'hA5, 1'b1);
        // run past one block without a start to wrap the position
        for (int i = 0; i < 36; i++)
            send_request(8'($urandom), 1'b0);
        send_request(8'h5A, 1'b1);
        drop_valid();
        wait_idle();
        cfg_write(3'd6, '1);
        cfg_write(3'd7, {$urandom, $urandom});
        cfg_all(1);
        send_request(8'hFF, 1'b1);
        send_request(8'h00, 1'b0);
        drop_valid();
        wait_idle();

        sent_count = 0;
        for (int phase = 0; sent_count < RANDOM_ITEMS; phase++)
        begin
            cfg_all((phase % 4 == 1) ? 1 : ((phase % 4 == 3) ? 0 : 2));
            if ($urandom_range(0, 1))
                cfg_write(3'($urandom_range(6, 7)), {$urandom, $urandom});
            while (sent_count < (phase + 1) * 340 && sent_count < RANDOM_ITEMS)
            begin
                int len;
                logic st;
                st = ($urandom_range(0, 4) != 0);
                len = st ? $urandom_range(1, 80) : $urandom_range(1, 40);
                for (int i = 0; i < len; i++)
                    send_request(8'($urandom), st && i == 0);
            end
            drop_valid();
            wait_idle();
        end

        if (errors == 0 && pending == 0)
            $display("[sha256_counter_keystream_xor] OK");
        else
            $display("[sha256_counter_keystream_xor] ERROR");
        $finish;
    end

endmodule

### sha256_counter_keystream_xor.f
src/skq_pkg.sv
src/skq_front.sv
src/skq_sha_core.sv
src/skq_back.sv
src/sha256_counter_keystream_xor.sv
src/skq_checker.sv
tb/sha256_keystream_checker.sv
tb/tb.sv
